[hw/rtl/sha512_pkg.sv]
// Package for the SHA-512 stream hasher: payload types, controller states,
// command/status structs, initial hash and round constants. No dependencies.
`default_nettype none
package sha512_pkg;

  typedef struct packed {
    logic [63:0] message_word;
    logic [3:0]  valid_bytes;
    logic        end_of_message;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_COMP,
    ST_FOLD,
    ST_EMIT
  } ctl_state_t;

  // word source codes for the block buffer write
  typedef enum logic [1:0] {
    SRC_INPUT,
    SRC_ZERO,
    SRC_LEN
  } word_src_t;

  typedef struct packed {
    logic      push;       // write one word into the block buffer
    word_src_t src;
    logic      count_in;   // add input bytes to the byte total
    logic      start;      // load working vars from chain value
    logic      round;      // run one round
    logic      fold;       // add working vars into chain value
    logic      reinit;     // restore initial hash, clear counters
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] word_fill;
    logic [6:0] round_index;
  } dp_stat_t;

  localparam int unsigned ROUNDS = 80;
  localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);
  localparam logic [3:0] LEN_SLOT = 4'd14;

  function automatic logic [63:0] init_hash(input logic [2:0] i);
    logic [63:0] v;
    unique case (i)
      3'd0: v = 64'h6a09e667f3bcc908;
      3'd1: v = 64'hbb67ae8584caa73b;
      3'd2: v = 64'h3c6ef372fe94f82b;
      3'd3: v = 64'ha54ff53a5f1d36f1;
      3'd4: v = 64'h510e527fade682d1;
      3'd5: v = 64'h9b05688c2b3e6c1f;
      3'd6: v = 64'h1f83d9abfb41bd6b;
      3'd7: v = 64'h5be0cd19137e2179;
      default: v = '0;
    endcase
    return v;
  endfunction

  localparam logic [63:0] K [ROUNDS] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

endpackage
`default_nettype wire

[hw/rtl/sha512_datapath.sv]
// SHA-512 datapath: block buffer as a 16-word shift line, byte counter,
// chain value and one round unit. Uses sha512_pkg; driven by sha512_ctrl.
`default_nettype none
module sha512_datapath
  import sha512_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire dp_cmd_t     cmd,
  input  wire in_beat_t    in_beat,
  input  wire logic [2:0]  out_sel,
  output dp_stat_t         stat,
  output logic [63:0]      out_word
);

  logic [63:0] w_r     [16];
  logic [63:0] h_r     [8];
  logic [63:0] v_r     [8];
  logic [3:0]  fill_r;
  logic [63:0] bytes_r;
  logic [6:0]  rnd_r;

  logic [3:0]  nbytes;
  logic [63:0] keep, padded, push_val, sched_new;
  logic [63:0] s0, s1, t1, t2, e, a;

  function automatic logic [63:0] ror(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  always_comb begin
    nbytes = (in_beat.valid_bytes > 4'd8) ? 4'd8 : in_beat.valid_bytes;
    if (!in_beat.end_of_message) nbytes = 4'd8;
    keep = (nbytes == 4'd0) ? 64'd0 : ~(64'hffffffffffffffff >> {nbytes, 3'b000});
    // a full final word goes in as is; its pad byte follows as a word of its own
    padded = (in_beat.message_word & keep) |
             ((nbytes == 4'd8) ? 64'd0 : (64'h80 << (7'd56 - {nbytes[2:0], 3'b000})));
    unique case (cmd.src)
      SRC_INPUT: push_val = in_beat.end_of_message ? padded : in_beat.message_word;
      SRC_ZERO:  push_val = 64'h8000000000000000 & {64{cmd.count_in}};
      SRC_LEN:   push_val = {bytes_r[60:0], 3'b000};
      default:   push_val = '0;
    endcase
  end

  // message schedule on the shift line: w_r[0] is the current word
  always_comb begin
    s0 = ror(w_r[1], 1) ^ ror(w_r[1], 8) ^ (w_r[1] >> 7);
    s1 = ror(w_r[14], 19) ^ ror(w_r[14], 61) ^ (w_r[14] >> 6);
    sched_new = w_r[0] + s0 + w_r[9] + s1;
    a = v_r[0];
    e = v_r[4];
    t1 = v_r[7] + (ror(e, 14) ^ ror(e, 18) ^ ror(e, 41)) + ((e & v_r[5]) ^ (~e & v_r[6]))
       + K[rnd_r] + w_r[0];
    t2 = (ror(a, 28) ^ ror(a, 34) ^ ror(a, 39)) + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= push_val;
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= sched_new;
    end
    if (cmd.start) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (cmd.round) begin
      for (int i = 1; i < 8; i++) v_r[i] <= v_r[i-1];
      v_r[4] <= v_r[3] + t1;
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reinit) begin
      for (int i = 0; i < 8; i++) h_r[i] <= init_hash(3'(i));
      fill_r  <= '0;
      bytes_r <= '0;
      rnd_r   <= '0;
    end else begin
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      end
      if (cmd.push) fill_r <= fill_r + 4'd1;
      if (cmd.count_in && cmd.src == SRC_INPUT) bytes_r <= bytes_r + 64'(nbytes);
      if (cmd.start) rnd_r <= '0;
      else if (cmd.round) rnd_r <= (rnd_r == LAST_ROUND) ? 7'd0 : rnd_r + 7'd1;
    end
  end

  assign stat.word_fill   = fill_r;
  assign stat.round_index = rnd_r;
  assign out_word         = h_r[out_sel];

`ifndef SYNTHESIS
  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n) rnd_r <= LAST_ROUND)
    else $error("round index out of range");
  a_no_push_round: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.push && cmd.round)) else $error("push during round");
  a_fold_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fold |-> rnd_r == 7'd0) else $error("fold before last round");
`endif

endmodule
`default_nettype wire

[hw/rtl/sha512_ctrl.sv]
// Controller for the SHA-512 hasher: sequences word pushes, padding,
// compressions and digest output. Uses sha512_pkg; drives sha512_datapath.
`default_nettype none
module sha512_ctrl
  import sha512_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_eom,
  input  wire logic [3:0] in_nbytes,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output logic [2:0]    out_sel,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  ctl_state_t st_r, st_nxt;
  logic       fin_r, fin_nxt;    // compression belongs to the final block
  logic       pad_r, pad_nxt;    // pad byte still owed (full final word)
  logic [2:0] sel_r, sel_nxt;
  logic       len_done_r;        // set once the length words went in for this message

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      fin_r <= 1'b0;
      pad_r <= 1'b0;
      sel_r <= '0;
    end else begin
      st_r  <= st_nxt;
      fin_r <= fin_nxt;
      pad_r <= pad_nxt;
      sel_r <= sel_nxt;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    fin_nxt  = fin_r;
    pad_nxt  = pad_r;
    sel_nxt  = sel_r;
    cmd      = '0;
    cmd.src  = SRC_INPUT;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.push = 1'b1;
          cmd.count_in = 1'b1;
          fin_nxt = in_eom;
          // counts above eight saturate, so they owe the pad byte too
          pad_nxt = in_eom && (in_nbytes >= 4'd8);
          if (stat.word_fill == 4'd15) st_nxt = ST_COMP;
          else if (in_eom) st_nxt = ST_PAD;
          cmd.start = (stat.word_fill == 4'd15);
        end
      end
      ST_PAD: begin
        // fill with zeros (pad byte first if owed) up to the length slot, or to block end and compress if past it
        cmd.push = 1'b1;
        cmd.src = SRC_ZERO;
        cmd.count_in = pad_r;
        pad_nxt = 1'b0;
        if (stat.word_fill == LEN_SLOT && !pad_r) begin
          cmd.push = 1'b0;
          st_nxt = ST_LEN_HI;
        end else if (stat.word_fill == 4'd15) begin
          cmd.start = 1'b1;
          st_nxt = ST_COMP;
        end
      end
      ST_LEN_HI: begin
        cmd.push = 1'b1;
        cmd.src = SRC_ZERO;
        st_nxt = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        cmd.push = 1'b1;
        cmd.src = SRC_LEN;
        cmd.start = 1'b1;
        fin_nxt = 1'b1;
        st_nxt = ST_COMP;
      end
      ST_COMP: begin
        cmd.round = 1'b1;
        if (stat.round_index == LAST_ROUND) st_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        sel_nxt = '0;
        // a final block that lacked room for the length goes back to padding
        if (!fin_r) st_nxt = ST_IDLE;
        else if (stat.word_fill == 4'd0 && pad_r == 1'b0 && st_r == ST_FOLD && len_done_r)
          st_nxt = ST_EMIT;
        else st_nxt = ST_PAD;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          sel_nxt = sel_r + 3'd1;
          if (sel_r == 3'd7) begin
            cmd.reinit = 1'b1;
            st_nxt = ST_IDLE;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reinit) len_done_r <= 1'b0;
    else if (st_r == ST_LEN_LO) len_done_r <= 1'b1;
  end

  assign out_sel = sel_r;

`ifndef SYNTHESIS
  a_emit_noin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken during digest output");
  a_len_fin: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_LEN_LO |=> fin_r) else $error("length block not final");
  a_emit_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> sel_r == 3'd0) else $error("digest not from word 0");
`endif

endmodule
`default_nettype wire

[hw/rtl/sha512_stream_hasher.sv]
// SHA-512 stream hasher. Message words are accepted one per cycle, while
// the controller is idle, into a 16-word buffer; each full block then runs
// 80 rounds, one per cycle in the single round unit, plus the chain fold.
// Input is not taken while a block is compressed. A final word adds padding
// pushes, one or two compressions, then eight digest beats, index 0 first.
`default_nettype none
module sha512_stream_hasher
  import sha512_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_beat_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_beat_t     out_data
);

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [2:0]  sel;
  logic [63:0] word;

  sha512_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_eom(in_data.end_of_message),
    .in_nbytes(in_data.valid_bytes), .in_ready, .out_valid, .out_ready,
    .out_sel(sel), .stat, .cmd
  );

  sha512_datapath u_dp (
    .clk, .rst_n, .cmd, .in_beat(in_data), .out_sel(sel), .stat, .out_word(word)
  );

  assign out_data.digest_word  = word;
  assign out_data.digest_index = sel;
  assign out_data.digest_last  = (sel == 3'd7);

endmodule
`default_nettype wire
